>>> sv/bbse_pkg.sv
package bbse_pkg;

	localparam int COORD_W = 32;
	localparam int PF = 16;
	localparam int PW = PF + 1;
	localparam int UW = PF + 5;
	localparam int ROW_W = COORD_W + PF + 4;
	localparam int ACC_W = ROW_W + PF + 4;
	localparam int DV_W = ACC_W - 2 * PF;
	localparam int GRID_N = 16;
	localparam int IDX_W = 4;
	localparam int Q_DEPTH = 2;
	localparam int DIV_BITS = 4;
	localparam int DIV_STEPS = DV_W / DIV_BITS;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [PW-1:0] P_ONE = PW'(1 << PF);

	typedef struct packed {
		logic                      cmd;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [PW-1:0]             s;
		logic [PW-1:0]             t;
	} item_t;

	typedef logic [3:0][UW-1:0] wts_t;

	function automatic logic [PW-1:0] clamp_param(input logic [PW-1:0] p);
		clamp_param = (p > P_ONE) ? P_ONE : p;
	endfunction

	// six times the cubic b-spline weights in units of 2^-PF
	function automatic wts_t basis_w(input logic [PW-1:0] p, input logic [PW-1:0] p2,
			input logic [PW-1:0] p3);
		logic signed [UW-1:0] a;
		logic signed [UW-1:0] b;
		logic signed [UW-1:0] c;
		logic signed [UW-1:0] one;
		wts_t w;
		a = UW'(p);
		b = UW'(p2);
		c = UW'(p3);
		one = UW'(P_ONE);
		w[0] = one - (a + a + a) + (b + b + b) - c;
		w[1] = (one <<< 2) - ((b <<< 2) + (b <<< 1)) + (c + c + c);
		w[2] = one + (a + a + a) + (b + b + b) - (c + c + c);
		w[3] = c;
		basis_w = w;
	endfunction

endpackage

>>> sv/bbse_front.sv
module bbse_front import bbse_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [IDX_W-1:0]          point_index,
	input  logic signed [COORD_W-1:0] ctrl_x,
	input  logic signed [COORD_W-1:0] ctrl_y,
	input  logic signed [COORD_W-1:0] ctrl_z,
	input  logic [PW-1:0]             s_param,
	input  logic [PW-1:0]             t_param,
	output item_t                     it,
	output logic                      it_valid,
	input  logic                      it_ready
);

	item_t item_q;
	logic  vld_q;

	assign in_ready = !vld_q || it_ready;
	assign it = item_q;
	assign it_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q.cmd <= cmd;
			item_q.idx <= point_index;
			item_q.x <= ctrl_x;
			item_q.y <= ctrl_y;
			item_q.z <= ctrl_z;
			// loads carry no parameters
			item_q.s <= (cmd == CMD_EVAL) ? clamp_param(s_param) : '0;
			item_q.t <= (cmd == CMD_EVAL) ? clamp_param(t_param) : '0;
		end
	end

endmodule

>>> sv/bbse_queue.sv
module bbse_queue import bbse_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t wr_item,
	input  logic  wr_valid,
	output logic  wr_ready,
	output item_t rd_item,
	output logic  rd_valid,
	input  logic  rd_ready
);

	localparam int PTR_W = $clog2(Q_DEPTH);

	item_t              mem_q [Q_DEPTH];
	logic [PTR_W-1:0]   wp_q;
	logic [PTR_W-1:0]   rp_q;
	logic [PTR_W:0]     cnt_q;
	logic               push;
	logic               pop;

	assign wr_ready = (cnt_q != (PTR_W + 1)'(Q_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_item;
		end
	end

endmodule

>>> sv/bbse_back.sv
module bbse_back import bbse_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  item_t                     q_item,
	input  logic                      q_valid,
	output logic                      q_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] pos_x,
	output logic signed [COORD_W-1:0] pos_y,
	output logic signed [COORD_W-1:0] pos_z,
	output logic                      clipped
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_B1   = 3'd1;
	localparam logic [2:0] ST_B2   = 3'd2;
	localparam logic [2:0] ST_B3   = 3'd3;
	localparam logic [2:0] ST_MAC  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_SAT  = 3'd7;

	localparam logic [4:0] MAC_LAST = 5'd19;
	localparam int DC_W = $clog2(DIV_STEPS);
	localparam logic [ACC_W-1:0] BIAS = ACC_W'(18) << (2 * PF);

	logic [2:0]                st_q;
	logic [4:0]                cnt_q;
	logic [DC_W-1:0]           dcnt_q;
	logic signed [COORD_W-1:0] grid_q [3][GRID_N];
	logic [PW-1:0]             s_q, t_q, s2_q, t2_q, s3_q, t3_q;
	wts_t                      us_q, ut_q;
	logic signed [ROW_W-1:0]   prod_s1 [3];
	logic signed [ROW_W-1:0]   row_s2 [3];
	logic signed [ACC_W-1:0]   rp_s3 [3];
	logic signed [ACC_W-1:0]   acc_q [3];
	logic [1:0]                pj_s1, pi_s1, ri_s2;
	logic                      pv_s1, rv_s2, rpv_s3;
	logic                      neg_q [3];
	logic [DV_W-1:0]           dvd_q [3];
	logic [DV_W-1:0]           quot_q [3];
	logic [5:0]                rem_q [3];
	logic                      res_vld_q;
	logic signed [COORD_W-1:0] res_q [3];
	logic                      clip_q;

	logic                      out_free;
	logic                      pop;
	logic signed [UW+COORD_W-1:0] pm [3];
	logic signed [UW+ROW_W-1:0]   rm [3];
	logic [DV_W-1:0]           nd [3];
	logic [DV_W-1:0]           nq [3];
	logic [5:0]                nr [3];
	logic signed [COORD_W-1:0] sat_v [3];
	logic                      sat_c [3];
	logic                      done_eval;

	assign out_free = !res_vld_q || out_ready;
	assign q_ready = (st_q == ST_IDLE) && out_free;
	assign pop = q_ready && q_valid;
	assign done_eval = (st_q == ST_SAT) && out_free;

	assign out_valid = res_vld_q;
	assign pos_x = res_q[0];
	assign pos_y = res_q[1];
	assign pos_z = res_q[2];
	assign clipped = clip_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pm[c] = $signed(ut_q[cnt_q[1:0]]) * grid_q[c][cnt_q[3:0]];
			rm[c] = $signed(us_q[ri_s2]) * row_s2[c];
		end
	end

	// long division by 36, DIV_BITS quotient bits per cycle
	always_comb begin
		logic [6:0] r7;
		for (int c = 0; c < 3; c++) begin
			nd[c] = dvd_q[c];
			nq[c] = quot_q[c];
			nr[c] = rem_q[c];
			for (int b = 0; b < DIV_BITS; b++) begin
				r7 = {nr[c], nd[c][DV_W-1]};
				nd[c] = nd[c] << 1;
				if (r7 >= 7'd36) begin
					r7 = r7 - 7'd36;
					nq[c] = {nq[c][DV_W-2:0], 1'b1};
				end else begin
					nq[c] = {nq[c][DV_W-2:0], 1'b0};
				end
				nr[c] = r7[5:0];
			end
		end
	end

	always_comb begin
		logic [DV_W-1:0] lim;
		logic [DV_W-1:0] mag;
		for (int c = 0; c < 3; c++) begin
			lim = (DV_W'(1) << (COORD_W - 1)) - (neg_q[c] ? DV_W'(0) : DV_W'(1));
			sat_c[c] = quot_q[c] > lim;
			mag = sat_c[c] ? lim : quot_q[c];
			sat_v[c] = neg_q[c] ? -mag[COORD_W-1:0] : mag[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			dcnt_q <= '0;
			res_vld_q <= 1'b0;
			pv_s1 <= 1'b0;
			rv_s2 <= 1'b0;
			rpv_s3 <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < GRID_N; k++) begin
					grid_q[c][k] <= '0;
				end
			end
		end else begin
			pv_s1 <= (st_q == ST_MAC) && !cnt_q[4];
			rv_s2 <= pv_s1 && (pj_s1 == 2'd3);
			rpv_s3 <= rv_s2;
			if ((pop && q_item.cmd == CMD_LOAD) || done_eval) begin
				res_vld_q <= 1'b1;
			end else if (out_ready) begin
				res_vld_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						if (q_item.cmd == CMD_LOAD) begin
							grid_q[0][q_item.idx] <= q_item.x;
							grid_q[1][q_item.idx] <= q_item.y;
							grid_q[2][q_item.idx] <= q_item.z;
						end else begin
							st_q <= ST_B1;
						end
					end
				end
				ST_B1: st_q <= ST_B2;
				ST_B2: st_q <= ST_B3;
				ST_B3: begin
					cnt_q <= '0;
					st_q <= ST_MAC;
				end
				ST_MAC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MAC_LAST) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					dcnt_q <= '0;
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DC_W'(DIV_STEPS - 1)) begin
						st_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic [2*PW-1:0]  sq;
		logic [ACC_W-1:0] mg;
		if (pop) begin
			s_q <= q_item.s;
			t_q <= q_item.t;
		end
		if (st_q == ST_B1) begin
			sq = s_q * s_q;
			s2_q <= sq[PF+PW-1:PF];
			sq = t_q * t_q;
			t2_q <= sq[PF+PW-1:PF];
		end
		if (st_q == ST_B2) begin
			sq = s2_q * s_q;
			s3_q <= sq[PF+PW-1:PF];
			sq = t2_q * t_q;
			t3_q <= sq[PF+PW-1:PF];
		end
		if (st_q == ST_B3) begin
			us_q <= basis_w(s_q, s2_q, s3_q);
			ut_q <= basis_w(t_q, t2_q, t3_q);
		end
		pj_s1 <= cnt_q[1:0];
		pi_s1 <= cnt_q[3:2];
		ri_s2 <= pi_s1;
		for (int c = 0; c < 3; c++) begin
			prod_s1[c] <= pm[c][ROW_W-1:0];
			if (pv_s1) begin
				row_s2[c] <= ((pj_s1 == 2'd0) ? '0 : row_s2[c]) + prod_s1[c];
			end
			rp_s3[c] <= rm[c][ACC_W-1:0];
			if (st_q == ST_B3) begin
				acc_q[c] <= '0;
			end else if (rpv_s3) begin
				acc_q[c] <= acc_q[c] + rp_s3[c];
			end
			if (st_q == ST_FIN) begin
				// round half away from zero on the magnitude
				neg_q[c] <= acc_q[c][ACC_W-1];
				mg = (acc_q[c][ACC_W-1] ? -acc_q[c] : acc_q[c]) + BIAS;
				dvd_q[c] <= mg[ACC_W-1:2*PF];
				quot_q[c] <= '0;
				rem_q[c] <= '0;
			end else if (st_q == ST_DIV) begin
				dvd_q[c] <= nd[c];
				quot_q[c] <= nq[c];
				rem_q[c] <= nr[c];
			end
		end
		if (pop && q_item.cmd == CMD_LOAD) begin
			for (int c = 0; c < 3; c++) begin
				res_q[c] <= '0;
			end
			clip_q <= 1'b0;
		end else if (done_eval) begin
			for (int c = 0; c < 3; c++) begin
				res_q[c] <= sat_v[c];
			end
			clip_q <= sat_c[0] || sat_c[1] || sat_c[2];
		end
	end

	a_mac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MAC) |-> (cnt_q <= MAC_LAST))
		else $error("mac counter past last step");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_item.cmd == CMD_LOAD) |=> (res_vld_q && !clip_q))
		else $error("load item gave no clean result");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (dcnt_q < DC_W'(DIV_STEPS)))
		else $error("divide counter out of range");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !pop)
		else $error("queue popped while evaluating");

endmodule

>>> sv/bicubic_bspline_patch_eval_core.sv
// uniform bicubic b-spline patch evaluator
// input channel (in_valid/in_ready): cmd 0 loads control point point_index
// of the 4x4 grid with ctrl_x/y/z, cmd 1 evaluates the patch at s_param,
// t_param (unsigned q1.16, values above 1.0 are clamped)
// output channel (out_valid/out_ready): one item per input item, pos_x/y/z
// in signed q16.16 and clipped when any coordinate saturated; loads give zeros
// an input register and a two-entry queue sit in front of the execution unit,
// so items keep being taken while a result waits on out_ready
// a load result is registered after the input register and queue, and loads
// stream at 1 item per cycle once queued while out_ready is high; an evaluate
// passes the input register and queue, the basis weights (ST_B1 to ST_B3),
// the 16-step grid multiply-accumulate (one grid point per cycle, x, y and z
// side by side, plus pipeline drain), rounding, the divide by 36, 4 bits a
// cycle, and saturation
// the execution unit handles one item at a time, so it takes no new item
// until an evaluate has finished saturation
// reset clears the grid to zeros and empties the queue; a stalled receiver
// holds the result and the unit waits before starting the next item
module bicubic_bspline_patch_eval_core import bbse_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [IDX_W-1:0]          point_index,
	input  logic signed [COORD_W-1:0] ctrl_x,
	input  logic signed [COORD_W-1:0] ctrl_y,
	input  logic signed [COORD_W-1:0] ctrl_z,
	input  logic [PW-1:0]             s_param,
	input  logic [PW-1:0]             t_param,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] pos_x,
	output logic signed [COORD_W-1:0] pos_y,
	output logic signed [COORD_W-1:0] pos_z,
	output logic                      clipped
);

	item_t f_item;
	logic  f_valid;
	logic  f_ready;
	item_t q_item;
	logic  q_valid;
	logic  q_ready;

	bbse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.point_index (point_index),
		.ctrl_x      (ctrl_x),
		.ctrl_y      (ctrl_y),
		.ctrl_z      (ctrl_z),
		.s_param     (s_param),
		.t_param     (t_param),
		.it          (f_item),
		.it_valid    (f_valid),
		.it_ready    (f_ready)
	);

	bbse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (f_item),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_item  (q_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	bbse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.clipped   (clipped)
	);

endmodule
